>>> design/b2da_pkg.sv
// shared constants and helpers for the binary to decimal ascii converter
package b2da_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 10;
	localparam int CHAR_W          = 6;
	localparam int DIGIT_W         = 4;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0]  char_t;

	// decimal digits needed for the largest value of a given bit width
	function automatic int num_digits(input int width);
		return ((width * 1233) >> 12) + 1;
	endfunction

	// ascii code of one decimal digit
	function automatic char_t to_char(input digit_t d);
		return ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
	endfunction

endpackage

>>> design/b2da_dabble_stage.sv
// one shift-add-3 pipeline stage, converts one binary bit into the bcd word
module b2da_dabble_stage #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
	parameter int NDIG        = b2da_pkg::num_digits(b2da_pkg::VALUE_WIDTH_DEF)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_vld,
	input  logic [NDIG*b2da_pkg::DIGIT_W-1:0]   in_bcd,
	input  logic [VALUE_WIDTH-1:0]              in_bits,
	output logic                                out_vld,
	output logic [NDIG*b2da_pkg::DIGIT_W-1:0]   out_bcd,
	output logic [VALUE_WIDTH-1:0]              out_bits
);

	localparam int BW = NDIG * b2da_pkg::DIGIT_W;

	logic [BW-1:0]          adj;
	logic [BW-1:0]          bcd_s1;
	logic [VALUE_WIDTH-1:0] bits_s1;
	logic                   vld_s1;

	// add 3 to every digit of five or more
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (in_bcd[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::BCD_ADJ_MIN) begin
				adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
					in_bcd[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::BCD_ADJ;
			end else begin
				adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
					in_bcd[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	// shift in the next binary bit, msb first
	always_ff @(posedge clk) begin
		if (adv) begin
			bcd_s1  <= {adj[BW-2:0], in_bits[VALUE_WIDTH-1]};
			bits_s1 <= {in_bits[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign out_vld  = vld_s1;
	assign out_bcd  = bcd_s1;
	assign out_bits = bits_s1;

endmodule

>>> design/b2da_count.sv
// digit count stage, finds how many digits a transaction will emit
module b2da_count #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
	parameter int NDIG       = b2da_pkg::num_digits(b2da_pkg::VALUE_WIDTH_DEF)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     adv,
	input  logic                                     in_vld,
	input  logic [NDIG*b2da_pkg::DIGIT_W-1:0]        in_bcd,
	output logic                                     out_vld,
	output logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0]  out_dig,
	output logic [$clog2(MAX_DIGITS+1)-1:0]          out_emit
);

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int DW = b2da_pkg::DIGIT_W;

	logic [CW-1:0]            emit;
	logic [MAX_DIGITS*DW-1:0] win;
	logic                     vld_s1;
	logic [CW-1:0]            emit_s1;
	logic [MAX_DIGITS*DW-1:0] dig_s1;

	// highest nonzero digit sets the count, zero still gives one digit
	always_comb begin
		emit = CW'(1);
		for (int i = 0; i < NDIG; i++) begin
			if (|in_bcd[i*DW +: DW]) begin
				emit = CW'((i + 1 >= MAX_DIGITS) ? MAX_DIGITS : i + 1);
			end
		end
	end

	// low digits that fit the output window
	always_comb begin
		for (int j = 0; j < MAX_DIGITS; j++) begin
			if (j < NDIG) begin
				win[j*DW +: DW] = in_bcd[j*DW +: DW];
			end else begin
				win[j*DW +: DW] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s1 <= emit;
			dig_s1  <= win;
		end
	end

	assign out_vld  = vld_s1;
	assign out_emit = emit_s1;
	assign out_dig  = dig_s1;

endmodule

>>> design/b2da_emit.sv
// output serializer, sends the digits of one transaction most significant first
module b2da_emit #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_vld,
	input  logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0]  in_dig,
	input  logic [$clog2(MAX_DIGITS+1)-1:0]          in_emit,
	output logic                                     adv,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output b2da_pkg::char_t                          digit_char,
	output logic                                     last_digit
);

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int IW = $clog2(MAX_DIGITS);
	localparam int DW = b2da_pkg::DIGIT_W;

	logic [MAX_DIGITS*DW-1:0] dig_q;
	logic [IW-1:0]            idx_q;
	logic                     vld_q;
	b2da_pkg::char_t          char_q;
	logic                     last_q;
	logic [IW-1:0]            ld_idx;
	logic [IW-1:0]            nxt_idx;
	logic                     load;
	logic                     step;

	assign adv     = !vld_q || (!out_stall && last_q);
	assign load    = adv && in_vld;
	assign step    = vld_q && !out_stall && !last_q;
	assign ld_idx  = IW'(in_emit - CW'(1));
	assign nxt_idx = idx_q - IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (adv) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q  <= in_dig;
			idx_q  <= ld_idx;
			char_q <= b2da_pkg::to_char(in_dig[ld_idx*DW +: DW]);
			last_q <= (in_emit == CW'(1));
		end else if (step) begin
			idx_q  <= nxt_idx;
			char_q <= b2da_pkg::to_char(dig_q[nxt_idx*DW +: DW]);
			last_q <= (idx_q == IW'(1));
		end
	end

	assign out_valid  = vld_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

>>> design/binary_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
//
//  channel | signals                            | role
//  --------+------------------------------------+--------------------------------------
//  input   | in_valid, in_stall, value          | one binary value per transaction
//  output  | out_valid, out_stall, digit_char,  | one ascii digit per transaction,
//          | last_digit                         | msb first, last_digit on the final one
//
//  a value passes one shift-add-3 stage per bit, then the digit count stage,
//  then the serializer register, before it reaches the output
//  the serializer then sends one digit per cycle while out_stall is low, and holds
//  a value for its digit count of 1 to MAX_DIGITS digits; this sets the sustained rate
//  arst_n clears every valid bit at once, payload registers keep garbage
//  the whole pipeline holds while the serializer has a digit that is not yet
//  the last one taken; an empty serializer never holds it, whatever out_stall does
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output b2da_pkg::char_t        digit_char,
	output logic                   last_digit
);

	// decimal digits of the widest value
	localparam int NDIG = b2da_pkg::num_digits(VALUE_WIDTH);
	localparam int BW   = NDIG * b2da_pkg::DIGIT_W;
	localparam int CW   = $clog2(MAX_DIGITS + 1);

	// global advance, every stage moves together
	logic adv;

	// stage chain, entry 0 is the input port
	logic                   chain_vld  [VALUE_WIDTH+1];
	logic [BW-1:0]          chain_bcd  [VALUE_WIDTH+1];
	logic [VALUE_WIDTH-1:0] chain_bits [VALUE_WIDTH+1];

	logic                                     cnt_vld;
	logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0]  cnt_dig;
	logic [CW-1:0]                            cnt_emit;

	assign chain_vld[0]  = in_valid;
	assign chain_bcd[0]  = '0;
	assign chain_bits[0] = value;

	// nothing is taken while the pipeline is held
	assign in_stall = !adv;

	// double dabble, one binary bit per stage
	for (genvar k = 0; k < VALUE_WIDTH; k++) begin : g_stage
		b2da_dabble_stage #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.NDIG       (NDIG)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (chain_vld[k]),
			.in_bcd  (chain_bcd[k]),
			.in_bits (chain_bits[k]),
			.out_vld (chain_vld[k+1]),
			.out_bcd (chain_bcd[k+1]),
			.out_bits(chain_bits[k+1])
		);
	end

	// count of significant digits, clipped to the output window
	b2da_count #(
		.MAX_DIGITS(MAX_DIGITS),
		.NDIG      (NDIG)
	) u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (chain_vld[VALUE_WIDTH]),
		.in_bcd  (chain_bcd[VALUE_WIDTH]),
		.out_vld (cnt_vld),
		.out_dig (cnt_dig),
		.out_emit(cnt_emit)
	);

	// serializer also decides when the pipeline may move
	b2da_emit #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (cnt_vld),
		.in_dig    (cnt_dig),
		.in_emit   (cnt_emit),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

endmodule

>>> design/b2da_checker.sv
// port level checks for the binary to decimal ascii converter
module b2da_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input b2da_pkg::char_t        digit_char,
	input logic                   last_digit
);

	// a stalled output transaction holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last_digit))
		else $error("stalled output transaction changed");

	// only decimal digit codes come out
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= b2da_pkg::ASCII_ZERO) &&
			(digit_char <= b2da_pkg::ASCII_ZERO + b2da_pkg::char_t'(9)))
		else $error("digit_char outside 0 to 9");

	// a run of digits has no gap until its last digit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_digit |=> out_valid)
		else $error("digit run broken before last digit");

	// an idle output never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output idle");

	// a held output holds the input side too
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.digit_char(digit_char),
	.last_digit(last_digit)
);
